### rtl/rpp_pkg.sv
// Package: payload types, register indexes, controller states and command types.
`default_nettype none
package rpp_pkg;
  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AddrBits = 5;
  localparam int unsigned StepBits = 10;
  localparam int unsigned RegCount = 12;
  localparam int unsigned RegBits = 4;
  localparam int unsigned DivCycles = 48;
  localparam int unsigned SqrtCycles = 24;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    word_t mom_x;
    word_t mom_y;
    word_t mom_z;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    logic  last_particle;
  } in_item_t;

  typedef struct packed {
    word_t new_mom_x;
    word_t new_mom_y;
    word_t new_mom_z;
    word_t new_pos_x;
    word_t new_pos_y;
    word_t new_pos_z;
    logic  sweep_end;
    logic  overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_KICK_X = 3'd0,
    REG_KICK_Y = 3'd1,
    REG_KICK_Z = 3'd2,
    REG_ROT_X  = 3'd3,
    REG_ROT_Y  = 3'd4,
    REG_ROT_Z  = 3'd5,
    REG_STEPS  = 3'd6
  } reg_idx_e;

  // Register file slots: u0..2, r3..5, k6..8, b9..11, plus scratch slots.
  localparam logic [RegBits-1:0] SlotU = 4'd0;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_ONE,
    SRC_ACC
  } src_e;

  // One micro-instruction: dst = a op b.
  typedef struct packed {
    logic          valid;
    alu_op_e       op;
    src_e          src_a;
    logic [4:0]    reg_a;
    src_e          src_b;
    logic [4:0]    reg_b;
    logic [4:0]    reg_d;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    uop_t uop;
    logic clear_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  // Multicycle unit state
  typedef enum logic [1:0] {
    MU_IDLE,
    MU_MUL,
    MU_DIV,
    MU_SQRT
  } mu_state_e;

  // Slot map (5-bit): 0-2 u, 3-5 r, 6-8 k, 9-11 b, 12-14 um, 15-17 t,
  // 18-20 s, 21-23 up, 24 g, 25 den, 26 tmp, 27 tmp2, 28 one, 29 acc.
  localparam int unsigned ProgLen = 64;

  function automatic uop_t mk(alu_op_e op, logic [4:0] a, logic [4:0] b, logic [4:0] d);
    uop_t u;
    u.valid = 1'b1;
    u.op    = op;
    u.src_a = SRC_REG;
    u.reg_a = a;
    u.src_b = SRC_REG;
    u.reg_b = b;
    u.reg_d = d;
    return u;
  endfunction

  // Program of one push, one micro-op per entry.
  function automatic uop_t prog(logic [5:0] pc);
    uop_t u;
    u = '0;
    case (pc)
      6'd0:  u = mk(OP_ADD, 5'd0, 5'd6, 5'd12);
      6'd1:  u = mk(OP_ADD, 5'd1, 5'd7, 5'd13);
      6'd2:  u = mk(OP_ADD, 5'd2, 5'd8, 5'd14);
      6'd3:  u = mk(OP_MUL, 5'd12, 5'd12, 5'd26);
      6'd4:  u = mk(OP_MUL, 5'd13, 5'd13, 5'd27);
      6'd5:  u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd6:  u = mk(OP_MUL, 5'd14, 5'd14, 5'd27);
      6'd7:  u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd8:  u = mk(OP_ADD, 5'd28, 5'd26, 5'd26);
      6'd9:  u = mk(OP_SQRT, 5'd26, 5'd26, 5'd24);
      6'd10: u = mk(OP_DIV, 5'd9, 5'd24, 5'd15);
      6'd11: u = mk(OP_DIV, 5'd10, 5'd24, 5'd16);
      6'd12: u = mk(OP_DIV, 5'd11, 5'd24, 5'd17);
      6'd13: u = mk(OP_MUL, 5'd15, 5'd15, 5'd26);
      6'd14: u = mk(OP_MUL, 5'd16, 5'd16, 5'd27);
      6'd15: u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd16: u = mk(OP_MUL, 5'd17, 5'd17, 5'd27);
      6'd17: u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd18: u = mk(OP_ADD, 5'd28, 5'd26, 5'd25);
      6'd19: u = mk(OP_ADD, 5'd15, 5'd15, 5'd26);
      6'd20: u = mk(OP_DIV, 5'd26, 5'd25, 5'd18);
      6'd21: u = mk(OP_ADD, 5'd16, 5'd16, 5'd26);
      6'd22: u = mk(OP_DIV, 5'd26, 5'd25, 5'd19);
      6'd23: u = mk(OP_ADD, 5'd17, 5'd17, 5'd26);
      6'd24: u = mk(OP_DIV, 5'd26, 5'd25, 5'd20);
      // up = um + um x t
      6'd25: u = mk(OP_MUL, 5'd13, 5'd17, 5'd26);
      6'd26: u = mk(OP_MUL, 5'd14, 5'd16, 5'd27);
      6'd27: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd28: u = mk(OP_ADD, 5'd12, 5'd26, 5'd21);
      6'd29: u = mk(OP_MUL, 5'd14, 5'd15, 5'd26);
      6'd30: u = mk(OP_MUL, 5'd12, 5'd17, 5'd27);
      6'd31: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd32: u = mk(OP_ADD, 5'd13, 5'd26, 5'd22);
      6'd33: u = mk(OP_MUL, 5'd12, 5'd16, 5'd26);
      6'd34: u = mk(OP_MUL, 5'd13, 5'd15, 5'd27);
      6'd35: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd36: u = mk(OP_ADD, 5'd14, 5'd26, 5'd23);
      // u = um + up x s + k
      6'd37: u = mk(OP_MUL, 5'd22, 5'd20, 5'd26);
      6'd38: u = mk(OP_MUL, 5'd23, 5'd19, 5'd27);
      6'd39: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd40: u = mk(OP_ADD, 5'd12, 5'd26, 5'd26);
      6'd41: u = mk(OP_ADD, 5'd26, 5'd6, 5'd0);
      6'd42: u = mk(OP_MUL, 5'd23, 5'd18, 5'd26);
      6'd43: u = mk(OP_MUL, 5'd21, 5'd20, 5'd27);
      6'd44: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd45: u = mk(OP_ADD, 5'd13, 5'd26, 5'd26);
      6'd46: u = mk(OP_ADD, 5'd26, 5'd7, 5'd1);
      6'd47: u = mk(OP_MUL, 5'd21, 5'd19, 5'd26);
      6'd48: u = mk(OP_MUL, 5'd22, 5'd18, 5'd27);
      6'd49: u = mk(OP_SUB, 5'd26, 5'd27, 5'd26);
      6'd50: u = mk(OP_ADD, 5'd14, 5'd26, 5'd26);
      6'd51: u = mk(OP_ADD, 5'd26, 5'd8, 5'd2);
      // gamma of new u, then r += u / gamma
      6'd52: u = mk(OP_MUL, 5'd0, 5'd0, 5'd26);
      6'd53: u = mk(OP_MUL, 5'd1, 5'd1, 5'd27);
      6'd54: u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd55: u = mk(OP_MUL, 5'd2, 5'd2, 5'd27);
      6'd56: u = mk(OP_ADD, 5'd26, 5'd27, 5'd26);
      6'd57: u = mk(OP_ADD, 5'd28, 5'd26, 5'd26);
      6'd58: u = mk(OP_SQRT, 5'd26, 5'd26, 5'd24);
      6'd59: u = mk(OP_DIV, 5'd0, 5'd24, 5'd26);
      6'd60: u = mk(OP_ADD, 5'd3, 5'd26, 5'd3);
      6'd61: u = mk(OP_DIV, 5'd1, 5'd24, 5'd26);
      6'd62: u = mk(OP_ADD, 5'd4, 5'd26, 5'd4);
      6'd63: u = mk(OP_DIV, 5'd2, 5'd24, 5'd26);
      default: u = '0;
    endcase
    return u;
  endfunction

  // Final op of a push (entry 64) lives in the controller: r_z += tmp.
  localparam logic [5:0] LastPc = 6'd63;
endpackage
`default_nettype wire

### rtl/relativistic_particle_push_core.sv
// Top level: configuration registers, controller and datapath.
// One particle at a time: each push runs 65 micro-ops in turn (nine divides,
// two roots, 21 products, 33 adds), and an item runs step_count pushes from
// acceptance to the result hand-off; the result then waits for out_ready_i.
`default_nettype none
module relativistic_particle_push_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rpp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rpp_pkg::out_item_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [rpp_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rpp_pkg::*;

  word_t kick_q [3];
  word_t rot_q [3];
  logic [StepBits-1:0] steps_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_q  <= '{default: '0};
      rot_q   <= '{default: '0};
      steps_q <= StepBits'(1);
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(idx))
        REG_KICK_X: kick_q[0] <= pwdata;
        REG_KICK_Y: kick_q[1] <= pwdata;
        REG_KICK_Z: kick_q[2] <= pwdata;
        REG_ROT_X:  rot_q[0]  <= pwdata;
        REG_ROT_Y:  rot_q[1]  <= pwdata;
        REG_ROT_Z:  rot_q[2]  <= pwdata;
        REG_STEPS:  steps_q   <= pwdata[StepBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(idx))
      REG_KICK_X: prdata = kick_q[0];
      REG_KICK_Y: prdata = kick_q[1];
      REG_KICK_Z: prdata = kick_q[2];
      REG_ROT_X:  prdata = rot_q[0];
      REG_ROT_Y:  prdata = rot_q[1];
      REG_ROT_Z:  prdata = rot_q[2];
      REG_STEPS:  prdata = 32'(steps_q);
      default:    prdata = '0;
    endcase
  end

  rpp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .steps_i(steps_q), .cmd_o(cmd), .sts_i(sts)
  );

  rpp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_data_i),
    .kick_i(kick_q), .rot_i(rot_q), .out_o(out_data_o)
  );
endmodule
`default_nettype wire

### rtl/rpp_datapath.sv
// Datapath: register file, saturating adder, multiplier, shared divide and root unit.
`default_nettype none
module rpp_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpp_pkg::dp_cmd_t  cmd_i,
  output rpp_pkg::dp_sts_t       sts_o,
  input  wire rpp_pkg::in_item_t in_i,
  input  wire rpp_pkg::word_t    kick_i [3],
  input  wire rpp_pkg::word_t    rot_i [3],
  output rpp_pkg::out_item_t     out_o
);
  import rpp_pkg::*;

  localparam logic signed [WordBits-1:0] WMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WMin = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic [WordBits-1:0] One = WordBits'(1) << FracBits;

  word_t rf_q [30];
  logic  ovf_q;
  logic  last_q;

  mu_state_e mu_q, mu_d;
  logic [5:0] cnt_q;
  logic [4:0] dst_q;
  logic       neg_q;
  logic [47:0] num_q;
  logic [32:0] rem_q;
  logic [47:0] quo_q;
  logic [31:0] dm_q;
  logic [63:0] prod_q;
  logic [33:0] srem_q;
  logic [31:0] root_q;

  word_t a, b;
  always_comb begin
    a = rf_q[cmd_i.uop.reg_a];
    b = rf_q[cmd_i.uop.reg_b];
  end

  function automatic logic [31:0] absw(word_t v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  logic signed [WordBits:0] sum;
  always_comb begin
    if (cmd_i.uop.op == OP_SUB) sum = {a[31], a} - {b[31], b};
    else sum = {a[31], a} + {b[31], b};
  end

  // Divide step: restoring, one quotient bit a cycle.
  logic [32:0] rtrial;
  logic [32:0] rshift;
  assign rshift = {rem_q[31:0], num_q[47]};
  assign rtrial = rshift - {1'b0, dm_q};

  // Root step: two radicand bits a cycle.
  logic [33:0] sshift;
  logic [33:0] strial;
  assign sshift = {srem_q[31:0], num_q[47:46]};
  assign strial = sshift - {root_q, 2'b01};

  // Multiply finishing: round, shift, saturate.
  logic [63:0] rnd;
  assign rnd = prod_q + (64'd1 << (FracBits - 1));
  logic [47:0] qmag;
  assign qmag = rnd[63:FracBits];

  word_t mres;
  logic  movf;
  always_comb begin
    movf = 1'b0;
    if (neg_q) begin
      if (qmag > 48'h80000000) begin
        mres = WMin;
        movf = 1'b1;
      end else begin
        mres = word_t'(-qmag[31:0]);
      end
    end else if (qmag > 48'h7fffffff) begin
      mres = WMax;
      movf = 1'b1;
    end else begin
      mres = word_t'(qmag[31:0]);
    end
  end

  word_t dres;
  logic  dovf;
  always_comb begin
    dovf = 1'b0;
    if (neg_q) begin
      if (quo_q > 48'h80000000) begin
        dres = WMin;
        dovf = 1'b1;
      end else begin
        dres = word_t'(-quo_q[31:0]);
      end
    end else if (quo_q > 48'h7fffffff) begin
      dres = WMax;
      dovf = 1'b1;
    end else begin
      dres = word_t'(quo_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= MU_IDLE;
    end else begin
      mu_q <= mu_d;
    end
  end

  always_comb begin
    mu_d = mu_q;
    case (mu_q)
      MU_IDLE: begin
        if (cmd_i.issue) begin
          case (cmd_i.uop.op)
            OP_MUL:  mu_d = MU_MUL;
            OP_DIV:  mu_d = MU_DIV;
            OP_SQRT: mu_d = MU_SQRT;
            default: mu_d = MU_IDLE;
          endcase
        end
      end
      MU_MUL: mu_d = MU_IDLE;
      MU_DIV, MU_SQRT: begin
        if (cnt_q == '0) mu_d = MU_IDLE;
      end
      default: mu_d = MU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) ovf_q <= 1'b0;
      case (mu_q)
        MU_IDLE: begin
          if (cmd_i.issue) begin
            dst_q <= cmd_i.uop.reg_d;
            case (cmd_i.uop.op)
              OP_ADD, OP_SUB: begin
                if (sum > 33'sd2147483647) begin
                  rf_q[cmd_i.uop.reg_d] <= WMax;
                  ovf_q <= 1'b1;
                end else if (sum < -33'sd2147483648) begin
                  rf_q[cmd_i.uop.reg_d] <= WMin;
                  ovf_q <= 1'b1;
                end else begin
                  rf_q[cmd_i.uop.reg_d] <= word_t'(sum);
                end
              end
              OP_MUL: begin
                prod_q <= absw(a) * absw(b);
                neg_q  <= a[31] ^ b[31];
              end
              OP_DIV: begin
                num_q <= {absw(a), 16'd0};
                dm_q  <= absw(b);
                neg_q <= a[31] ^ b[31];
                rem_q <= '0;
                quo_q <= '0;
                cnt_q <= 6'(DivCycles);
              end
              OP_SQRT: begin
                num_q  <= a[31] ? 48'd0 : {a, 16'd0};
                srem_q <= '0;
                root_q <= '0;
                neg_q  <= 1'b0;
                cnt_q  <= 6'(SqrtCycles);
              end
              default: ;
            endcase
          end
        end
        MU_MUL: begin
          rf_q[dst_q] <= mres;
          if (movf) ovf_q <= 1'b1;
        end
        MU_DIV: begin
          if (cnt_q == '0) begin
            rf_q[dst_q] <= dres;
            if (dovf) ovf_q <= 1'b1;
          end else begin
            num_q <= {num_q[46:0], 1'b0};
            if (!rtrial[32]) begin
              rem_q <= rtrial;
              quo_q <= {quo_q[46:0], 1'b1};
            end else begin
              rem_q <= rshift;
              quo_q <= {quo_q[46:0], 1'b0};
            end
            cnt_q <= cnt_q - 6'd1;
          end
        end
        MU_SQRT: begin
          if (cnt_q == '0) begin
            rf_q[dst_q] <= word_t'(root_q);
          end else begin
            num_q <= {num_q[45:0], 2'b00};
            if (!strial[33]) begin
              srem_q <= strial;
              root_q <= {root_q[30:0], 1'b1};
            end else begin
              srem_q <= sshift;
              root_q <= {root_q[30:0], 1'b0};
            end
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: ;
      endcase
      if (cmd_i.load) begin
        rf_q[0]  <= in_i.mom_x;
        rf_q[1]  <= in_i.mom_y;
        rf_q[2]  <= in_i.mom_z;
        rf_q[3]  <= in_i.pos_x;
        rf_q[4]  <= in_i.pos_y;
        rf_q[5]  <= in_i.pos_z;
        rf_q[6]  <= kick_i[0];
        rf_q[7]  <= kick_i[1];
        rf_q[8]  <= kick_i[2];
        rf_q[9]  <= rot_i[0];
        rf_q[10] <= rot_i[1];
        rf_q[11] <= rot_i[2];
        rf_q[28] <= word_t'(One);
        last_q   <= in_i.last_particle;
      end
    end
  end

  assign sts_o.busy = (mu_q != MU_IDLE) || cmd_i.issue;
  assign sts_o.done = (mu_q == MU_IDLE);

  always_comb begin
    out_o.new_mom_x  = rf_q[0];
    out_o.new_mom_y  = rf_q[1];
    out_o.new_mom_z  = rf_q[2];
    out_o.new_pos_x  = rf_q[3];
    out_o.new_pos_y  = rf_q[4];
    out_o.new_pos_z  = rf_q[5];
    out_o.sweep_end  = last_q;
    out_o.overflowed = ovf_q;
  end
endmodule
`default_nettype wire

### rtl/rpp_ctrl.sv
// Controller: sequences the micro-program of one push per step.
`default_nettype none
module rpp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire logic [rpp_pkg::StepBits-1:0] steps_i,
  output rpp_pkg::dp_cmd_t           cmd_o,
  input  wire rpp_pkg::dp_sts_t      sts_i
);
  import rpp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [6:0] pc_q, pc_d;
  logic [StepBits-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    step_d  = step_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d   = '0;
          step_d = steps_i;
          state_d = (steps_i == '0) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sts_i.done) begin
          cmd_o.issue = 1'b1;
          if (pc_q == 7'd64) cmd_o.uop = mk(OP_ADD, 5'd5, 5'd26, 5'd5);
          else cmd_o.uop = prog(pc_q[5:0]);
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          if (pc_q == 7'd64) begin
            pc_d = '0;
            step_d = step_q - 1'b1;
            state_d = (step_q == StepBits'(1)) ? ST_OUT : ST_ISSUE;
          end else begin
            pc_d = pc_q + 7'd1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/rpp_checker.sv
// Port checker for the particle push core, bound to the top level.
`default_nettype none
module rpp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic pready
);
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("took two requests");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind relativistic_particle_push_core rpp_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .pready
);
`default_nettype wire
